/* rtl/rffca_pkg.sv */
// Shared types and constants of the first-fit rectangle cell allocator.
// No dependencies; all other files but rffca_colmem refer to it by scoped names.
`default_nettype none

package rffca_pkg;

    // Stream word layout
    localparam int PIX_W      = 16;   // pixel size fields
    localparam int POS_W      = 4;    // cell position fields
    localparam int SIZE_W     = 5;    // cell size fields
    localparam int IN_DATA_W  = 56;   // 50 payload bits padded to bytes
    localparam int OUT_DATA_W = 24;   // 18 payload bits padded to bytes

    // Pixel to cell rounding: quotient of a 17 bit dividend by reciprocal
    localparam int QUO_W       = PIX_W + 1;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Operation codes carried in the input tuser
    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_FREE    = 1'b1;

    // Placed rectangle, last field in the lowest bits
    typedef struct packed {
        logic [SIZE_W-1:0] h;
        logic [SIZE_W-1:0] w;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  x;
    } area_t;

endpackage

`default_nettype wire

/* rtl/rffca_colmem.sv */
// Occupancy column memory: one word of row bits per grid column, one read
// and one write port, registered read data. Does not use rffca_pkg.
`default_nettype none

module rffca_colmem #(
    parameter int GRID_W = 16,
    parameter int GRID_H = 16,
    parameter int AW     = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [GRID_H-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [GRID_H-1:0] wr_data
);

    logic [GRID_H-1:0] col_mem [GRID_W];
    logic [GRID_H-1:0] rd_data_reg;
    logic [GRID_W-1:0] valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= col_mem[rd_addr];
        end
    end

    // A column never written since reset reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* rtl/rffca_round.sv */
// Rounds a pixel size up to whole cells by a reciprocal multiply with a
// registered product. Uses rffca_pkg for widths and the reciprocal shift.
`default_nettype none

module rffca_round #(
    parameter int CELL_PIXELS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [rffca_pkg::PIX_W-1:0] pixels,
    output logic      [rffca_pkg::QUO_W-1:0] cells
);

    localparam int PROD_W = rffca_pkg::QUO_W + rffca_pkg::RECIP_W;
    // ceil(2^S / C); exact for every dividend below 2^17 at any C up to 256
    localparam logic [rffca_pkg::RECIP_W-1:0] RECIP = rffca_pkg::RECIP_W'(
        ((64'd1 << rffca_pkg::RECIP_SHIFT) + 64'(CELL_PIXELS) - 64'd1) / 64'(CELL_PIXELS));

    logic [rffca_pkg::QUO_W-1:0] dividend;
    logic [PROD_W-1:0]           prod_reg;

    assign dividend = {1'b0, pixels} + rffca_pkg::QUO_W'(CELL_PIXELS - 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(dividend) * PROD_W'(RECIP);
        end
    end

    assign cells = prod_reg[rffca_pkg::RECIP_SHIFT +: rffca_pkg::QUO_W];

endmodule

`default_nettype wire

/* rtl/rect_first_fit_cell_allocator.sv */
// First-fit rectangle allocator over a GRID_W x GRID_H cell bitmap, top level.
// Depends on rffca_pkg, rffca_colmem and rffca_round.
`default_nettype none

// The block keeps one occupancy bit per cell, all free after reset, stored as
// one memory word of row bits per grid column. A reserve word (tuser = 0)
// rounds its pixel width and height up to whole cells and searches columns
// left to right, rows top to bottom, for the first free rectangle; it marks
// the cells used and returns ok = 1 with place and size, or ok = 0 and zeros
// when nothing fits. A zero-sized request succeeds at (0,0) and marks nothing.
// A free word (tuser = 1) clears a rectangle given in cells, ignoring cells
// outside the grid, and returns ok = 1 with zeros. One word is processed at a
// time. A free reads, clears and writes back each freed column that lies inside
// the grid, then posts the result. A reserve first rounds the sizes and checks
// them, then for each candidate column x ORs the w covered columns out through
// the single read port of the column memory and scans the result one row per
// cycle for a run of h free rows; on a fit it marks the cells in the w columns
// and posts the result. The memory read port and the bit-serial row scan set
// its speed. No clearing pass follows reset: per-column valid bits make
// unwritten columns read as free. A finished result sits in an output
// register, so the next word is taken while it waits.
module rect_first_fit_cell_allocator #(
    parameter int GRID_W      = 16,
    parameter int GRID_H      = 16,
    parameter int CELL_PIXELS = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // req_width[15:0], req_height[31:16], free_x[35:32], free_y[39:36],
    // free_w[44:40], free_h[49:45], zero pad above
    input  wire logic [rffca_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // area_x[3:0], area_y[7:4], area_w[12:8], area_h[17:13], zero pad above
    output logic      [rffca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // done_ok[0]
    output logic                                  m_axis_tuser
);

    localparam int AW     = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW     = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int GMAX   = (GRID_W > GRID_H) ? GRID_W : GRID_H;
    // Counters hold grid sizes and column sums, free fields included
    localparam int CW     = $clog2(GMAX + 32) + 1;
    localparam int PAD_W  = rffca_pkg::OUT_DATA_W - $bits(rffca_pkg::area_t);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ROUND  = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_GATHER = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_MODIFY = 8'b0010_0000,
        ST_RESP   = 8'b0100_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [rffca_pkg::PIX_W-1:0]    rw_reg, rw_next;
    logic [rffca_pkg::PIX_W-1:0]    rh_reg, rh_next;
    logic [CW-1:0]                  w_reg, w_next;
    logic [CW-1:0]                  h_reg, h_next;
    logic [CW-1:0]                  x_reg, x_next;
    logic [CW-1:0]                  y_reg, y_next;
    logic [CW-1:0]                  run_reg, run_next;
    logic [CW-1:0]                  k_reg, k_next;
    logic [CW-1:0]                  start_reg, start_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  lo_reg, lo_next;
    logic [CW-1:0]                  len_reg, len_next;
    logic                           set_reg, set_next;
    logic [GRID_H-1:0]              acc_reg, acc_next;
    logic                           pend_reg, pend_next;
    logic [AW-1:0]                  pend_addr_reg, pend_addr_next;
    rffca_pkg::area_t               res_area_reg, res_area_next;
    logic                           res_ok_reg, res_ok_next;
    rffca_pkg::area_t               out_area_reg, out_area_next;
    logic                           out_ok_reg, out_ok_next;
    logic                           out_valid_reg, out_valid_next;

    logic [rffca_pkg::QUO_W-1:0]    cells_w, cells_h;
    logic                           round_en;
    logic                           rd_en, wr_en;
    logic [AW-1:0]                  rd_addr, wr_addr;
    logic [GRID_H-1:0]              rd_data, wr_data;
    logic [GRID_H-1:0]              mask;
    logic [CW-1:0]                  col_sum;
    logic                           issue;
    logic [CW:0]                    lo_end;

    rffca_round #(
        .CELL_PIXELS (CELL_PIXELS)
    ) u_round_w (
        .clk    (clk),
        .en     (round_en),
        .pixels (rw_reg),
        .cells  (cells_w)
    );

    rffca_round #(
        .CELL_PIXELS (CELL_PIXELS)
    ) u_round_h (
        .clk    (clk),
        .en     (round_en),
        .pixels (rh_reg),
        .cells  (cells_h)
    );

    rffca_colmem #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .AW     (AW)
    ) u_colmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign round_en = (state_reg == ST_ROUND);

    // Row mask of the rectangle being marked or cleared; rows past the grid drop out
    assign lo_end = {1'b0, lo_reg} + {1'b0, len_reg};
    always_comb
    begin
        for (int b = 0; b < GRID_H; b++)
        begin
            mask[b] = (CW'(b) >= lo_reg) && ((CW + 1)'(b) < lo_end);
        end
    end

    // Column walk shared by the gather and modify passes
    assign col_sum = start_reg + k_reg;
    assign issue   = ((state_reg == ST_GATHER) || (state_reg == ST_MODIFY))
                     && (k_reg < count_reg) && (col_sum < CW'(GRID_W));
    assign rd_en   = issue;
    assign rd_addr = col_sum[AW-1:0];
    assign wr_en   = (state_reg == ST_MODIFY) && pend_reg;
    assign wr_addr = pend_addr_reg;
    assign wr_data = set_reg ? (rd_data | mask) : (rd_data & ~mask);

    always_comb
    begin
        logic          row_used;
        logic [CW-1:0] run_inc;

        state_next     = state_reg;
        rw_next        = rw_reg;
        rh_next        = rh_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        run_next       = run_reg;
        k_next         = k_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        len_next       = len_reg;
        set_next       = set_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        res_area_next  = res_area_reg;
        res_ok_next    = res_ok_reg;
        out_area_next  = out_area_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg;
        row_used       = acc_reg[y_reg[YW-1:0]];
        run_inc        = row_used ? '0 : run_reg + CW'(1);

        // Drop the result once the sink takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (issue)
        begin
            k_next         = k_reg + CW'(1);
            pend_next      = 1'b1;
            pend_addr_next = col_sum[AW-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rw_next = s_axis_tdata[15:0];
                    rh_next = s_axis_tdata[31:16];
                    if (s_axis_tuser == rffca_pkg::OP_FREE)
                    begin
                        start_next    = CW'(s_axis_tdata[35:32]);
                        lo_next       = CW'(s_axis_tdata[39:36]);
                        count_next    = CW'(s_axis_tdata[44:40]);
                        len_next      = CW'(s_axis_tdata[49:45]);
                        set_next      = 1'b0;
                        k_next        = '0;
                        res_ok_next   = 1'b1;
                        res_area_next = '0;
                        state_next    = ST_MODIFY;
                    end
                    else
                    begin
                        state_next = ST_ROUND;
                    end
                end
            end

            ST_ROUND:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if ((cells_w > rffca_pkg::QUO_W'(GRID_W))
                    || (cells_h > rffca_pkg::QUO_W'(GRID_H)))
                begin
                    res_ok_next   = 1'b0;
                    res_area_next = '0;
                    state_next    = ST_RESP;
                end
                else if ((cells_w == '0) || (cells_h == '0))
                begin
                    // Empty rectangle: place at the origin, mark nothing
                    res_ok_next     = 1'b1;
                    res_area_next.x = '0;
                    res_area_next.y = '0;
                    res_area_next.w = cells_w[rffca_pkg::SIZE_W-1:0];
                    res_area_next.h = cells_h[rffca_pkg::SIZE_W-1:0];
                    state_next      = ST_RESP;
                end
                else
                begin
                    w_next     = cells_w[CW-1:0];
                    h_next     = cells_h[CW-1:0];
                    x_next     = '0;
                    start_next = '0;
                    count_next = cells_w[CW-1:0];
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = ST_GATHER;
                end
            end

            ST_GATHER:
            begin
                // OR the covered columns into one row-occupancy word
                if (pend_reg)
                begin
                    acc_next = acc_reg | rd_data;
                end
                if (!issue && !pend_reg)
                begin
                    y_next     = '0;
                    run_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (run_inc == h_reg)
                begin
                    res_ok_next     = 1'b1;
                    res_area_next.x = x_reg[rffca_pkg::POS_W-1:0];
                    res_area_next.y = rffca_pkg::POS_W'(y_reg + CW'(1) - h_reg);
                    res_area_next.w = w_reg[rffca_pkg::SIZE_W-1:0];
                    res_area_next.h = h_reg[rffca_pkg::SIZE_W-1:0];
                    start_next      = x_reg;
                    count_next      = w_reg;
                    lo_next         = y_reg + CW'(1) - h_reg;
                    len_next        = h_reg;
                    set_next        = 1'b1;
                    k_next          = '0;
                    state_next      = ST_MODIFY;
                end
                else if (y_reg == CW'(GRID_H - 1))
                begin
                    if ((x_reg + w_reg) >= CW'(GRID_W))
                    begin
                        res_ok_next   = 1'b0;
                        res_area_next = '0;
                        state_next    = ST_RESP;
                    end
                    else
                    begin
                        x_next     = x_reg + CW'(1);
                        start_next = x_reg + CW'(1);
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = ST_GATHER;
                    end
                end
                else
                begin
                    y_next   = y_reg + CW'(1);
                    run_next = run_inc;
                end
            end

            ST_MODIFY:
            begin
                // Each column is written back in the cycle after its read
                if (!issue && !pend_reg)
                begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                // Hold until the output register is free or being emptied
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_area_next  = res_area_reg;
                    out_ok_next    = res_ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rw_reg        <= rw_next;
        rh_reg        <= rh_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        run_reg       <= run_next;
        k_reg         <= k_next;
        start_reg     <= start_next;
        count_reg     <= count_next;
        lo_reg        <= lo_next;
        len_reg       <= len_next;
        set_reg       <= set_next;
        acc_reg       <= acc_next;
        pend_addr_reg <= pend_addr_next;
        res_area_reg  <= res_area_next;
        res_ok_reg    <= res_ok_next;
        out_area_reg  <= out_area_next;
        out_ok_reg    <= out_ok_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_area_reg};
    assign m_axis_tuser  = out_ok_reg;

endmodule

`default_nettype wire

/* rtl/rffca_checker.sv */
// Port-level checks for the rectangle allocator and the bind that attaches
// them to rect_first_fit_cell_allocator. Uses rffca_pkg for word widths.
`default_nettype none

module rffca_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [rffca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                             m_axis_tuser
);

    // One word in flight: the input closes right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted a second word back to back");

    // A failed reserve reports zero place and size
    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("failed result carries nonzero area");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind rect_first_fit_cell_allocator rffca_checker u_rffca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
